// ----- rtl/core/ckbh_pkg.sv -----
// Shared constants and types for the canonical k-mer bucket histogram core.
// No dependencies; compiled first.
package ckbh_pkg;

  localparam int unsigned MaxEdgeChars = 128;
  localparam int unsigned PrefixChars  = 8;
  localparam int unsigned CountBits    = 32;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned EdgeLenMin   = 2;

  localparam logic [7:0] EdgeLenReset = 8'd32;

  typedef enum logic {
    KIND_PUSH  = 1'b0,
    KIND_QUERY = 1'b1
  } ckbh_kind_e;

  // Classified word handed from front to back (address travels beside it).
  typedef struct packed {
    ckbh_kind_e  kind;
    logic        strand;
    logic        oor;
    logic [15:0] bucket;
  } ckbh_tag_t;

endpackage

// ----- rtl/core/ckbh_if.sv -----
// Valid/ready channel interfaces for item input and result output.
// No dependencies.
interface ckbh_item_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [1:0]  base;
  logic        read_start;
  logic [15:0] query_bucket;

  modport source(output valid, action, base, read_start, query_bucket, input ready);
  modport sink(input valid, action, base, read_start, query_bucket, output ready);
endinterface

interface ckbh_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [15:0] bucket;
  logic        strand;
  logic [31:0] bucket_count;

  modport source(output valid, result_kind, bucket, strand, bucket_count, input ready);
  modport sink(input valid, result_kind, bucket, strand, bucket_count, output ready);
endinterface

// ----- rtl/core/ckbh_front.sv -----
// Front end: takes words, keeps the rolling window, picks the canonical strand
// and bucket. Depends on ckbh_pkg and ckbh_item_if.
module ckbh_front #(
  parameter int unsigned MAX_EDGE_CHARS = ckbh_pkg::MaxEdgeChars,
  parameter int unsigned PREFIX_CHARS   = ckbh_pkg::PrefixChars
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [7:0]                  edge_len_i,
  input  logic                        hold_i,
  ckbh_item_if.sink                   item_i,
  output logic                        push_valid_o,
  input  logic                        push_ready_i,
  output ckbh_pkg::ckbh_tag_t         push_tag_o,
  output logic [2*PREFIX_CHARS-1:0]   push_addr_o
);
  import ckbh_pkg::*;

  localparam int unsigned WW = 2 * MAX_EDGE_CHARS;
  localparam int unsigned AW = 2 * PREFIX_CHARS;
  localparam int unsigned SW = $clog2(WW);
  localparam logic [8:0] MaxLen = 9'(MAX_EDGE_CHARS);
  localparam logic [8:0] MinLen = 9'(EdgeLenMin);

  logic [WW-1:0] win_q, win_d;
  logic [7:0]    bir_q, bir_d, bir_base;
  logic          a_valid_q, a_valid_d;
  ckbh_kind_e    a_kind_q, a_kind_d;
  logic [15:0]   a_query_q, a_query_d;

  logic [8:0]    edge_ext, len, len_gap;
  logic [SW-1:0] shamt;
  logic [WW-1:0] fwd_aligned, rc_raw, rc_mask, rc_aligned, canon;
  logic          rev;
  logic [31:0]   q_ext;
  logic          accept;
  ckbh_kind_e    in_kind;

  // effective window length
  always_comb begin
    edge_ext = {1'b0, edge_len_i};
    if (edge_ext < MinLen) begin
      len = MinLen;
    end else if (edge_ext > MaxLen) begin
      len = MaxLen;
    end else begin
      len = edge_ext;
    end
    len_gap = MaxLen - len;
    shamt   = SW'({len_gap, 1'b0});
  end

  // window char 0 is newest; aligned strings put first char at the MSB
  always_comb begin
    for (int i = 0; i < MAX_EDGE_CHARS; i++) begin
      rc_raw[2*(MAX_EDGE_CHARS-1-i) +: 2] = ~win_q[2*i +: 2];
    end
    fwd_aligned = win_q << shamt;
    rc_mask     = {WW{1'b1}} << shamt;
    rc_aligned  = rc_raw & rc_mask;
    rev         = rc_aligned < fwd_aligned;
    canon       = rev ? rc_aligned : fwd_aligned;
  end

  always_comb begin
    q_ext = 32'(a_query_q);
    push_tag_o.kind = a_kind_q;
    if (a_kind_q == KIND_QUERY) begin
      push_tag_o.strand = 1'b0;
      push_tag_o.oor    = (q_ext >> AW) != 32'd0;
      push_tag_o.bucket = a_query_q;
      push_addr_o       = q_ext[AW-1:0];
    end else begin
      push_tag_o.strand = rev;
      push_tag_o.oor    = 1'b0;
      push_tag_o.bucket = 16'(canon[WW-1 -: AW]);
      push_addr_o       = canon[WW-1 -: AW];
    end
  end

  assign push_valid_o = a_valid_q;
  assign item_i.ready = !hold_i && (!a_valid_q || push_ready_i);
  assign accept       = item_i.valid && item_i.ready;
  assign in_kind      = ckbh_kind_e'(item_i.action);

  always_comb begin
    win_d     = win_q;
    bir_d     = bir_q;
    bir_base  = bir_q;
    a_valid_d = a_valid_q;
    a_kind_d  = a_kind_q;
    a_query_d = a_query_q;
    if (accept) begin
      a_kind_d  = in_kind;
      a_query_d = item_i.query_bucket;
      if (in_kind == KIND_QUERY) begin
        a_valid_d = 1'b1;
      end else begin
        win_d     = {win_q[WW-3:0], item_i.base};
        bir_base  = item_i.read_start ? 8'd0 : bir_q;
        bir_d     = (bir_base == 8'hFF) ? bir_base : bir_base + 8'd1;
        a_valid_d = {1'b0, bir_d} >= len;
      end
    end else if (push_ready_i) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      bir_q     <= 8'd0;
    end else begin
      a_valid_q <= a_valid_d;
      bir_q     <= bir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q     <= win_d;
    a_kind_q  <= a_kind_d;
    a_query_q <= a_query_d;
  end

`ifndef SYNTHESIS
  a_query_staged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_kind == KIND_QUERY) |=> (a_valid_q && a_kind_q == KIND_QUERY))
    else $error("accepted query not staged");
`endif

endmodule

// ----- rtl/core/ckbh_queue.sv -----
// Short word queue decoupling front and back.
// Depends on ckbh_pkg for defaults.
module ckbh_queue #(
  parameter int unsigned WIDTH = $bits(ckbh_pkg::ckbh_tag_t) + 2 * ckbh_pkg::PrefixChars,
  parameter int unsigned DEPTH = ckbh_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign push_ready_o = cnt_q != CNTW'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = slots_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNTW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNTW'(DEPTH))
    else $error("queue occupancy out of range");
`endif

endmodule

// ----- rtl/core/ckbh_back.sv -----
// Back end: histogram memory with clear sweep, read-modify-write and result register.
// Depends on ckbh_pkg and ckbh_result_if.
module ckbh_back #(
  parameter int unsigned PREFIX_CHARS = ckbh_pkg::PrefixChars,
  parameter int unsigned COUNT_BITS   = ckbh_pkg::CountBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      pop_valid_i,
  output logic                      pop_ready_o,
  input  ckbh_pkg::ckbh_tag_t       pop_tag_i,
  input  logic [2*PREFIX_CHARS-1:0] pop_addr_i,
  output logic                      clearing_o,
  ckbh_result_if.source             result_o
);
  import ckbh_pkg::*;

  localparam int unsigned AW = 2 * PREFIX_CHARS;
  localparam int unsigned NB = 1 << AW;
  localparam int unsigned CW = COUNT_BITS;

  function automatic logic [31:0] clip32(logic [CW-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  logic [CW-1:0] hist_mem [NB];

  logic          clr_busy_q, clr_busy_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;
  logic          s1_valid_q, s1_valid_d;
  ckbh_tag_t     s1_tag_q;
  logic [AW-1:0] s1_addr_q;
  logic [CW-1:0] rd_q;
  logic          lw_valid_q, lw_valid_d;
  logic [AW-1:0] lw_addr_q;
  logic [CW-1:0] lw_data_q;
  logic          out_valid_q, out_valid_d;
  ckbh_kind_e    out_kind_q;
  logic [15:0]   out_bucket_q;
  logic          out_strand_q;
  logic [31:0]   out_count_q;

  logic          pop, s1_adv, s1_write;
  logic [CW-1:0] cur_cnt, inc_cnt;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [CW-1:0] mem_wdata;

  assign s1_adv      = s1_valid_q && (!out_valid_q || result_o.ready);
  assign s1_write    = s1_adv && (s1_tag_q.kind == KIND_PUSH);
  assign pop_ready_o = !clr_busy_q && (!s1_valid_q || s1_adv);
  assign pop         = pop_valid_i && pop_ready_o;
  assign clearing_o  = clr_busy_q;

  // bypass the write that landed on the same edge as this word's read
  assign cur_cnt = (lw_valid_q && lw_addr_q == s1_addr_q) ? lw_data_q : rd_q;
  assign inc_cnt = (cur_cnt == {CW{1'b1}}) ? cur_cnt : cur_cnt + CW'(1);

  assign mem_we    = clr_busy_q || s1_write;
  assign mem_waddr = clr_busy_q ? clr_addr_q : s1_addr_q;
  assign mem_wdata = clr_busy_q ? '0 : inc_cnt;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      clr_busy_d = clr_addr_q != {AW{1'b1}};
    end
    s1_valid_d  = pop ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
    out_valid_d = s1_adv ? 1'b1 : (result_o.ready ? 1'b0 : out_valid_q);
    lw_valid_d  = s1_write ? 1'b1 : lw_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      lw_valid_q  <= 1'b0;
    end else begin
      clr_busy_q  <= clr_busy_d;
      clr_addr_q  <= clr_addr_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      lw_valid_q  <= lw_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    if (pop) begin
      rd_q <= hist_mem[pop_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_tag_q  <= pop_tag_i;
      s1_addr_q <= pop_addr_i;
    end
    if (s1_write) begin
      lw_addr_q <= s1_addr_q;
      lw_data_q <= inc_cnt;
    end
    if (s1_adv) begin
      out_kind_q   <= s1_tag_q.kind;
      out_bucket_q <= s1_tag_q.bucket;
      out_strand_q <= s1_tag_q.strand;
      if (s1_tag_q.kind == KIND_PUSH) begin
        out_count_q <= clip32(inc_cnt);
      end else begin
        out_count_q <= s1_tag_q.oor ? 32'd0 : clip32(cur_cnt);
      end
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.result_kind  = 1'(out_kind_q);
  assign result_o.bucket       = out_bucket_q;
  assign result_o.strand       = out_strand_q;
  assign result_o.bucket_count = out_count_q;

`ifndef SYNTHESIS
  clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_busy_q |=> !clr_busy_q)
    else $error("clear sweep restarted");

  clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> (!s1_valid_q && !out_valid_q))
    else $error("word in flight during clear sweep");

  push_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == KIND_PUSH) |-> (out_count_q != 32'd0))
    else $error("window result with zero count");
`endif

endmodule

// ----- rtl/core/canonical_kmer_bucket_histogram_core.sv -----
// Canonical k-mer bucket histogram: one item per cycle sustained, back to back, while
// results are taken and no clear sweep runs. A result passes the front stage,
// queue and histogram read stage feeding the output register.
// Reset: the window fill count and valid flags clear at once; a clear sweep then
// writes all 4**PREFIX_CHARS histogram entries (65536 by default) with input ready low.
// Depends on ckbh_pkg, ckbh_if, ckbh_front, ckbh_queue, ckbh_back.
module canonical_kmer_bucket_histogram_core #(
  parameter int unsigned MAX_EDGE_CHARS = ckbh_pkg::MaxEdgeChars,
  parameter int unsigned PREFIX_CHARS   = ckbh_pkg::PrefixChars,
  parameter int unsigned COUNT_BITS     = ckbh_pkg::CountBits
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_wdata_i,
  ckbh_item_if.sink      item_i,
  ckbh_result_if.source  result_o
);
  import ckbh_pkg::*;

  localparam int unsigned AW = 2 * PREFIX_CHARS;
  localparam int unsigned TW = $bits(ckbh_tag_t);
  localparam int unsigned QW = TW + AW;

  logic [7:0]    edge_len_q;
  logic          push_valid, push_ready, pop_valid, pop_ready, clearing;
  ckbh_tag_t     push_tag, pop_tag;
  logic [AW-1:0] push_addr, pop_addr;
  logic [QW-1:0] pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_len_q <= EdgeLenReset;
    end else if (cfg_we_i) begin
      edge_len_q <= cfg_wdata_i;
    end
  end

  ckbh_front #(
    .MAX_EDGE_CHARS(MAX_EDGE_CHARS),
    .PREFIX_CHARS  (PREFIX_CHARS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .edge_len_i  (edge_len_q),
    .hold_i      (clearing),
    .item_i      (item_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_tag_o  (push_tag),
    .push_addr_o (push_addr)
  );

  ckbh_queue #(
    .WIDTH(QW),
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i ({push_tag, push_addr}),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  assign pop_tag  = ckbh_tag_t'(pop_data[QW-1:AW]);
  assign pop_addr = pop_data[AW-1:0];

  ckbh_back #(
    .PREFIX_CHARS(PREFIX_CHARS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_tag_i  (pop_tag),
    .pop_addr_i (pop_addr),
    .clearing_o (clearing),
    .result_o   (result_o)
  );

endmodule
